// ===== rtl/core/tgr_pkg.sv =====
`default_nettype none

package tgr_pkg;

    // Coordinate width of the touch controller samples.
    localparam int COORD_BITS = 12;

    // Fixed register widths.
    localparam int THR_W  = 12;
    localparam int MS_W   = 16;
    localparam int SIZE_W = 13;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 4;
    localparam int KIND_W = 3;

    // Compare widths wide enough for both operands.
    localparam int CMP_W  = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
    localparam int DIST_W = (COORD_BITS > THR_W) ? COORD_BITS : THR_W;

    // Plan queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // APB register map.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int RIDX_W  = 3;

    typedef enum logic [RIDX_W-1:0] {
        REG_MOVE_LIMIT      = 3'd0,
        REG_LONG_PRESS_MS   = 3'd1,
        REG_HOLD_RADIUS     = 3'd2,
        REG_CLICK_WINDOW_MS = 3'd3,
        REG_PANEL_W         = 3'd4,
        REG_PANEL_H         = 3'd5
    } reg_idx_t;

    localparam logic [THR_W-1:0]  MOVE_LIMIT_RST      = 12'd5;
    localparam logic [MS_W-1:0]   LONG_PRESS_MS_RST   = 16'd500;
    localparam logic [THR_W-1:0]  HOLD_RADIUS_RST     = 12'd20;
    localparam logic [MS_W-1:0]   CLICK_WINDOW_MS_RST = 16'd200;
    localparam logic [SIZE_W-1:0] PANEL_W_RST         = 13'd800;
    localparam logic [SIZE_W-1:0] PANEL_H_RST         = 13'd480;

    typedef enum logic [KIND_W-1:0] {
        EV_POS           = 3'd0,
        EV_LEFT_PRESS    = 3'd1,
        EV_LEFT_RELEASE  = 3'd2,
        EV_RIGHT_PRESS   = 3'd3,
        EV_RIGHT_RELEASE = 3'd4
    } ev_kind_t;

    typedef struct packed {
        logic [CNT_W-1:0]      touch_count;
        logic [COORD_BITS-1:0] raw_x;
        logic [COORD_BITS-1:0] raw_y;
        logic [TIME_W-1:0]     now_ms;
    } sample_t;

    typedef struct packed {
        logic [KIND_W-1:0]     event_kind;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic                  last;
    } gesture_t;

    typedef struct packed {
        logic [THR_W-1:0]  move_limit;
        logic [MS_W-1:0]   long_press_ms;
        logic [THR_W-1:0]  hold_radius;
        logic [MS_W-1:0]   click_window_ms;
        logic [SIZE_W-1:0] panel_w;
        logic [SIZE_W-1:0] panel_h;
    } cfg_t;

    // One classified sample: up to three words, in order ev0, ev1, ev2.
    typedef struct packed {
        logic [1:0]            cnt;
        ev_kind_t              ev0;
        ev_kind_t              ev1;
        ev_kind_t              ev2;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } plan_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic [COORD_BITS-1:0] v,
        input logic [SIZE_W-1:0]     size
    );
        logic [CMP_W-1:0] top;
        logic [CMP_W-1:0] vw;
        top = (size == '0) ? '0 : (CMP_W'(size) - CMP_W'(1));
        vw  = CMP_W'(v);
        return (vw > top) ? COORD_BITS'(top) : v;
    endfunction

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/touch_gesture_recognizer.sv =====
// Touch gesture recognizer.
// Sample channel (sample_valid/sample_ready/sample): one polled touch sample
// per word: touch count, raw x/y and a millisecond timestamp.
// Gesture channel (gesture_valid/gesture_ready/gesture): zero to three words
// per sample, in order: a position word while touched, then left press,
// left release, right press or right release words; last marks the final
// word of a sample. A lift with nothing to report gives no word at all.
// Configuration is an APB slave with six registers at byte offsets 0..20;
// pready is tied high and reads return the register value.
// The front classifies a sample and updates the touch state in the cycle it
// is taken, then hands a plan to a two-entry queue. The back walks the plan
// through an output register, one word per cycle while the receiver is ready.
// On an idle block the first word of a sample passes the queue entry and
// then the output register before it shows.
// Throughput: one gesture word per cycle while gesture_ready is high; the
// front takes a sample every cycle while the queue has room.
// Reset clears touch state, the queue and the output, and loads register
// defaults. When the receiver stalls, hold the output word; the queue fills
// and sample_ready drops until it drains.

`default_nettype none

module touch_gesture_recognizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tgr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tgr_pkg::PDATA_W-1:0]   pwdata,
    output logic [tgr_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          sample_valid,
    output logic                               sample_ready,
    input  wire tgr_pkg::sample_t              sample,
    output logic                               gesture_valid,
    input  wire logic                          gesture_ready,
    output tgr_pkg::gesture_t                  gesture
);

    tgr_pkg::cfg_t        cfg_reg, cfg_next;
    tgr_pkg::reg_idx_t    ridx;
    logic                 wr_en;
    logic                 push, pop;
    tgr_pkg::plan_t       plan, head;
    tgr_pkg::q_status_t   q_status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign ridx   = tgr_pkg::reg_idx_t'(paddr[tgr_pkg::RIDX_W+1:2]);

    // Register writes; offsets past the map are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (ridx)
                tgr_pkg::REG_MOVE_LIMIT:
                    cfg_next.move_limit = pwdata[tgr_pkg::THR_W-1:0];
                tgr_pkg::REG_LONG_PRESS_MS:
                    cfg_next.long_press_ms = pwdata[tgr_pkg::MS_W-1:0];
                tgr_pkg::REG_HOLD_RADIUS:
                    cfg_next.hold_radius = pwdata[tgr_pkg::THR_W-1:0];
                tgr_pkg::REG_CLICK_WINDOW_MS:
                    cfg_next.click_window_ms = pwdata[tgr_pkg::MS_W-1:0];
                tgr_pkg::REG_PANEL_W:
                    cfg_next.panel_w = pwdata[tgr_pkg::SIZE_W-1:0];
                tgr_pkg::REG_PANEL_H:
                    cfg_next.panel_h = pwdata[tgr_pkg::SIZE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Read mux, zero-extended to the bus width.
    always_comb
    begin
        case (ridx)
            tgr_pkg::REG_MOVE_LIMIT:
                prdata = tgr_pkg::PDATA_W'(cfg_reg.move_limit);
            tgr_pkg::REG_LONG_PRESS_MS:
                prdata = tgr_pkg::PDATA_W'(cfg_reg.long_press_ms);
            tgr_pkg::REG_HOLD_RADIUS:
                prdata = tgr_pkg::PDATA_W'(cfg_reg.hold_radius);
            tgr_pkg::REG_CLICK_WINDOW_MS:
                prdata = tgr_pkg::PDATA_W'(cfg_reg.click_window_ms);
            tgr_pkg::REG_PANEL_W:
                prdata = tgr_pkg::PDATA_W'(cfg_reg.panel_w);
            tgr_pkg::REG_PANEL_H:
                prdata = tgr_pkg::PDATA_W'(cfg_reg.panel_h);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_limit      <= tgr_pkg::MOVE_LIMIT_RST;
            cfg_reg.long_press_ms   <= tgr_pkg::LONG_PRESS_MS_RST;
            cfg_reg.hold_radius     <= tgr_pkg::HOLD_RADIUS_RST;
            cfg_reg.click_window_ms <= tgr_pkg::CLICK_WINDOW_MS_RST;
            cfg_reg.panel_w         <= tgr_pkg::PANEL_W_RST;
            cfg_reg.panel_h         <= tgr_pkg::PANEL_H_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: take a sample, classify it, advance touch state.
    tgr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .q_status     (q_status),
        .push         (push),
        .plan         (plan)
    );

    // Plan queue decouples classification from word delivery.
    tgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (plan),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Back: emit the plan one word per cycle while the receiver is ready.
    tgr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .gesture_valid (gesture_valid),
        .gesture_ready (gesture_ready),
        .gesture       (gesture)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tgr_front.sv =====
`default_nettype none

module tgr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tgr_pkg::cfg_t     cfg,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire tgr_pkg::sample_t  sample,
    input  wire tgr_pkg::q_status_t q_status,
    output logic                   push,
    output tgr_pkg::plan_t         plan
);

    logic                                touching_reg, touching_next;
    logic                                dragging_reg, dragging_next;
    logic                                lp_done_reg, lp_done_next;
    logic [tgr_pkg::COORD_BITS-1:0]      anchor_x_reg, anchor_x_next;
    logic [tgr_pkg::COORD_BITS-1:0]      anchor_y_reg, anchor_y_next;
    logic [tgr_pkg::TIME_W-1:0]          anchor_time_reg, anchor_time_next;

    logic                                accept;
    logic                                touched;
    logic [tgr_pkg::TIME_W-1:0]          dt;
    logic [tgr_pkg::COORD_BITS-1:0]      x, y, dx, dy;
    logic [tgr_pkg::DIST_W-1:0]          dxw, dyw, thr, lpdist;
    logic                                drag_fire, lp_fire;

    assign sample_ready = !q_status.full;
    assign accept       = sample_valid && sample_ready;
    assign touched      = (sample.touch_count != '0);
    assign dt           = sample.now_ms - anchor_time_reg;

    assign x   = tgr_pkg::clamp_coord(sample.raw_x, cfg.panel_w);
    assign y   = tgr_pkg::clamp_coord(sample.raw_y, cfg.panel_h);
    assign dx  = tgr_pkg::abs_diff(x, anchor_x_reg);
    assign dy  = tgr_pkg::abs_diff(y, anchor_y_reg);
    assign dxw = tgr_pkg::DIST_W'(dx);
    assign dyw = tgr_pkg::DIST_W'(dy);
    assign thr    = tgr_pkg::DIST_W'(cfg.move_limit);
    assign lpdist = tgr_pkg::DIST_W'(cfg.hold_radius);

    // A drag on this sample blocks the long press on the same sample.
    assign drag_fire = touching_reg && !dragging_reg && !lp_done_reg
                       && (dxw > thr || dyw > thr);
    assign lp_fire   = touching_reg && !dragging_reg && !lp_done_reg && !drag_fire
                       && (dt > tgr_pkg::TIME_W'(cfg.long_press_ms))
                       && (dxw < lpdist) && (dyw < lpdist);

    always_comb
    begin
        touching_next    = touching_reg;
        dragging_next    = dragging_reg;
        lp_done_next     = lp_done_reg;
        anchor_x_next    = anchor_x_reg;
        anchor_y_next    = anchor_y_reg;
        anchor_time_next = anchor_time_reg;
        plan.cnt = 2'd0;
        plan.ev0 = tgr_pkg::EV_POS;
        plan.ev1 = tgr_pkg::EV_POS;
        plan.ev2 = tgr_pkg::EV_POS;
        plan.x   = x;
        plan.y   = y;
        if (touched)
        begin
            plan.cnt = 2'd1;
            if (!touching_reg)
            begin
                anchor_x_next    = x;
                anchor_y_next    = y;
                anchor_time_next = sample.now_ms;
                touching_next    = 1'b1;
                lp_done_next     = 1'b0;
            end
            else if (drag_fire)
            begin
                plan.cnt      = 2'd2;
                plan.ev1      = tgr_pkg::EV_LEFT_PRESS;
                dragging_next = 1'b1;
            end
            else if (lp_fire)
            begin
                plan.cnt     = 2'd3;
                plan.ev1     = tgr_pkg::EV_RIGHT_PRESS;
                plan.ev2     = tgr_pkg::EV_RIGHT_RELEASE;
                lp_done_next = 1'b1;
            end
        end
        else if (touching_reg)
        begin
            if (dragging_reg)
            begin
                plan.cnt      = 2'd1;
                plan.ev0      = tgr_pkg::EV_LEFT_RELEASE;
                dragging_next = 1'b0;
            end
            else if (!lp_done_reg && dt < tgr_pkg::TIME_W'(cfg.click_window_ms))
            begin
                plan.cnt = 2'd2;
                plan.ev0 = tgr_pkg::EV_LEFT_PRESS;
                plan.ev1 = tgr_pkg::EV_LEFT_RELEASE;
            end
            touching_next = 1'b0;
            lp_done_next  = 1'b0;
        end
    end

    // Drop samples that give no words; nothing enters the queue for them.
    assign push = accept && (plan.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touching_reg    <= 1'b0;
            dragging_reg    <= 1'b0;
            lp_done_reg     <= 1'b0;
            anchor_x_reg    <= '0;
            anchor_y_reg    <= '0;
            anchor_time_reg <= '0;
        end
        else if (accept)
        begin
            touching_reg    <= touching_next;
            dragging_reg    <= dragging_next;
            lp_done_reg     <= lp_done_next;
            anchor_x_reg    <= anchor_x_next;
            anchor_y_reg    <= anchor_y_next;
            anchor_time_reg <= anchor_time_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tgr_queue.sv =====
`default_nettype none

module tgr_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tgr_pkg::plan_t     push_data,
    input  wire logic               pop,
    output tgr_pkg::plan_t          head,
    output tgr_pkg::q_status_t      status
);

    tgr_pkg::plan_t                mem_reg [tgr_pkg::QDEPTH];
    logic [tgr_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tgr_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tgr_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    assign status.full  = (count_reg == tgr_pkg::QCNT_W'(tgr_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == tgr_pkg::QPTR_W'(tgr_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tgr_pkg::QPTR_W'(tgr_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tgr_back.sv =====
`default_nettype none

module tgr_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tgr_pkg::plan_t     head,
    input  wire tgr_pkg::q_status_t q_status,
    output logic                    pop,
    output logic                    gesture_valid,
    input  wire logic               gesture_ready,
    output tgr_pkg::gesture_t       gesture
);

    logic [1:0]           idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    tgr_pkg::gesture_t    word_reg, word_next;
    logic                 load;
    logic                 is_last;
    tgr_pkg::ev_kind_t    kind;

    assign load    = !q_status.empty && (!valid_reg || gesture_ready);
    assign is_last = (idx_reg == (head.cnt - 2'd1));
    assign pop     = load && is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    kind = head.ev0;
            2'd1:    kind = head.ev1;
            default: kind = head.ev2;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        word_next  = word_reg;
        valid_next = valid_reg && !gesture_ready;
        if (load)
        begin
            valid_next           = 1'b1;
            word_next.event_kind = kind;
            word_next.last       = is_last;
            // Button words carry a zero position.
            word_next.pos_x = (kind == tgr_pkg::EV_POS) ? head.x : '0;
            word_next.pos_y = (kind == tgr_pkg::EV_POS) ? head.y : '0;
            idx_next        = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign gesture_valid = valid_reg;
    assign gesture       = word_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tgr_checker.sv =====
`default_nettype none

module tgr_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pready,
    input  wire logic               gesture_valid,
    input  wire logic               gesture_ready,
    input  wire tgr_pkg::gesture_t  gesture
);

    // Hold a stalled word.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && !gesture_ready |=> gesture_valid && $stable(gesture))
        else $error("gesture word dropped or changed under stall");

    // Button words carry no position.
    a_button_pos: assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && (gesture.event_kind != tgr_pkg::EV_POS)
        |-> (gesture.pos_x == '0) && (gesture.pos_y == '0))
        else $error("button word with nonzero position");

    // A right press is always followed by its release in the same sample.
    a_right_press: assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && (gesture.event_kind == tgr_pkg::EV_RIGHT_PRESS)
        |-> !gesture.last)
        else $error("right press marked last");

    a_right_release: assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && (gesture.event_kind == tgr_pkg::EV_RIGHT_RELEASE)
        |-> gesture.last)
        else $error("right release not marked last");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pready        (pready),
    .gesture_valid (gesture_valid),
    .gesture_ready (gesture_ready),
    .gesture       (gesture)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Use the spare slot at the top of the map to show that writes outside
    // the register list leave every setting alone.
    localparam logic [tgr_pkg::RIDX_W-1:0] REG_UNMAPPED = 3'd7;

    localparam int SETTLE_CYCLES  = 8;     // let a silent lift clear the pipe
    localparam int CHOKE_CYCLES   = 80;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [tgr_pkg::PADDR_W-1:0]   paddr   = '0;
    logic [tgr_pkg::PDATA_W-1:0]   pwdata  = '0;
    logic [tgr_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    logic               sample_valid  = 1'b0;
    logic               sample_ready;
    tgr_pkg::sample_t   sample        = '0;
    logic               gesture_valid;
    logic               gesture_ready = 1'b0;
    tgr_pkg::gesture_t  gesture;

    touch_gesture_recognizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .gesture_valid (gesture_valid),
        .gesture_ready (gesture_ready),
        .gesture       (gesture)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Gesture predictor: our own copy of the touch state and the settings.
    // ------------------------------------------------------------------
    tgr_pkg::cfg_t                  cfg_now;
    logic                           touching;
    logic                           dragging;
    logic                           long_press_done;
    logic [tgr_pkg::COORD_BITS-1:0] anchor_x;
    logic [tgr_pkg::COORD_BITS-1:0] anchor_y;
    logic [tgr_pkg::TIME_W-1:0]     anchor_ms;

    tgr_pkg::gesture_t gesture_exp[$];     // words still owed by the block, oldest first
    tgr_pkg::sample_t  sample_pending[$];  // samples waiting for the driver

    int n_errors       = 0;
    int samples_queued = 0;
    int samples_sent   = 0;
    int words_checked  = 0;
    int n_left_press   = 0;
    int n_right_press  = 0;
    int n_settings     = 1;

    // Pull a raw coordinate onto the screen; a zero size behaves as one.
    function automatic logic [tgr_pkg::COORD_BITS-1:0] fit_to_screen(
        input logic [tgr_pkg::COORD_BITS-1:0] raw,
        input logic [tgr_pkg::SIZE_W-1:0]     size
    );
        int unsigned top;
        top = (size == '0) ? 0 : size - 1;
        return (raw > top) ? tgr_pkg::COORD_BITS'(top) : raw;
    endfunction

    function automatic logic [tgr_pkg::COORD_BITS-1:0] spread_of(
        input logic [tgr_pkg::COORD_BITS-1:0] a,
        input logic [tgr_pkg::COORD_BITS-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic tgr_pkg::gesture_t gesture_word(
        input tgr_pkg::ev_kind_t              kind,
        input logic [tgr_pkg::COORD_BITS-1:0] x,
        input logic [tgr_pkg::COORD_BITS-1:0] y
    );
        tgr_pkg::gesture_t g;
        g.event_kind = kind;
        g.pos_x      = x;
        g.pos_y      = y;
        g.last       = 1'b0;
        return g;
    endfunction

    // Advance the touch state by one sample and queue the words it owes.
    function automatic void predict_gestures(input tgr_pkg::sample_t s);
        tgr_pkg::gesture_t              words [3];
        int                             n;
        logic [tgr_pkg::COORD_BITS-1:0] x;
        logic [tgr_pkg::COORD_BITS-1:0] y;
        logic [tgr_pkg::COORD_BITS-1:0] dx;
        logic [tgr_pkg::COORD_BITS-1:0] dy;
        logic [tgr_pkg::TIME_W-1:0]     held;
        n    = 0;
        held = s.now_ms - anchor_ms;   // wraps like the timestamp does
        if (s.touch_count != '0)
        begin
            x = fit_to_screen(s.raw_x, cfg_now.panel_w);
            y = fit_to_screen(s.raw_y, cfg_now.panel_h);
            words[n] = gesture_word(tgr_pkg::EV_POS, x, y);
            n++;
            if (!touching)
            begin
                anchor_x        = x;
                anchor_y        = y;
                anchor_ms       = s.now_ms;
                touching        = 1'b1;
                long_press_done = 1'b0;
            end
            else
            begin
                dx = spread_of(x, anchor_x);
                dy = spread_of(y, anchor_y);
                // Drag is judged first; once it fires it blocks the long press.
                if (!dragging && !long_press_done &&
                    (dx > cfg_now.move_limit || dy > cfg_now.move_limit))
                begin
                    dragging = 1'b1;
                    words[n] = gesture_word(tgr_pkg::EV_LEFT_PRESS, '0, '0);
                    n++;
                end
                if (!dragging && !long_press_done && held > cfg_now.long_press_ms &&
                    dx < cfg_now.hold_radius &&
                    dy < cfg_now.hold_radius)
                begin
                    words[n] = gesture_word(tgr_pkg::EV_RIGHT_PRESS, '0, '0);
                    n++;
                    words[n] = gesture_word(tgr_pkg::EV_RIGHT_RELEASE, '0, '0);
                    n++;
                    long_press_done = 1'b1;
                end
            end
        end
        else if (touching)
        begin
            if (dragging)
            begin
                words[n] = gesture_word(tgr_pkg::EV_LEFT_RELEASE, '0, '0);
                n++;
                dragging = 1'b0;
            end
            else if (!long_press_done && held < cfg_now.click_window_ms)
            begin
                words[n] = gesture_word(tgr_pkg::EV_LEFT_PRESS, '0, '0);
                n++;
                words[n] = gesture_word(tgr_pkg::EV_LEFT_RELEASE, '0, '0);
                n++;
            end
            touching        = 1'b0;
            long_press_done = 1'b0;
        end
        // A lift while untouched owes nothing.
        if (n > 0)
            words[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            gesture_exp.push_back(words[i]);
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: present one word at a time, idle for up to tx_max
    // after each accepted word.
    // ------------------------------------------------------------------
    int tx_max = 3;
    int tx_wait = 0;
    bit tx_busy;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            tx_busy = sample_valid;
            if (sample_valid && sample_ready)
            begin
                predict_gestures(sample);
                samples_sent++;
                tx_busy = 1'b0;
                tx_wait = $urandom_range(0, tx_max);
            end
            if (!tx_busy)
            begin
                if (tx_wait > 0)
                    tx_wait--;
                else if (sample_pending.size() > 0)
                begin
                    sample  <= sample_pending.pop_front();
                    tx_busy = 1'b1;
                end
            end
            // One assignment per edge: valid stays high across back-to-back words.
            sample_valid <= tx_busy;
        end
    end

    // ------------------------------------------------------------------
    // Gesture monitor: check each accepted word against the oldest
    // expectation, then stall for up to rx_max. A bump of choke_seq from
    // the stimulus makes it hold ready low for a long stretch.
    // ------------------------------------------------------------------
    int                rx_max = 3;
    int                rx_wait = 0;
    int                choke_seq = 0;
    int                choke_seen = 0;
    int                choke_left = 0;
    tgr_pkg::gesture_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (choke_seq != choke_seen)
            begin
                choke_seen = choke_seq;
                choke_left = CHOKE_CYCLES;
            end
            if (gesture_valid && gesture_ready)
            begin
                words_checked++;
                if (gesture.event_kind == tgr_pkg::EV_LEFT_PRESS)
                    n_left_press++;
                if (gesture.event_kind == tgr_pkg::EV_RIGHT_PRESS)
                    n_right_press++;
                if (gesture_exp.size() == 0)
                begin
                    $error("gesture word with no sample owing it: event_kind %0d",
                           gesture.event_kind);
                    n_errors++;
                end
                else
                begin
                    want = gesture_exp.pop_front();
                    if (gesture.event_kind !== want.event_kind)
                    begin
                        $error("event_kind: expected %0d, got %0d",
                               want.event_kind, gesture.event_kind);
                        n_errors++;
                    end
                    if (gesture.pos_x !== want.pos_x)
                    begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, gesture.pos_x);
                        n_errors++;
                    end
                    if (gesture.pos_y !== want.pos_y)
                    begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, gesture.pos_y);
                        n_errors++;
                    end
                    if (gesture.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, gesture.last);
                        n_errors++;
                    end
                end
                rx_wait = $urandom_range(0, rx_max);
            end
            if (choke_left > 0)
            begin
                choke_left--;
                gesture_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                gesture_ready <= 1'b0;
            end
            else
                gesture_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop out if no handshake of any kind happens for too long.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) ||
            (gesture_valid && gesture_ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without progress, %0d words still owed",
                     quiet_cycles, gesture_exp.size());
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [tgr_pkg::TIME_W-1:0] ms_now;

    // Write one register over APB: setup cycle, then access cycle.
    task automatic write_reg(input logic [tgr_pkg::RIDX_W-1:0] idx,
                             input logic [tgr_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tgr_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tgr_pkg::REG_MOVE_LIMIT:
                cfg_now.move_limit      = value[tgr_pkg::THR_W-1:0];
            tgr_pkg::REG_LONG_PRESS_MS:
                cfg_now.long_press_ms   = value[tgr_pkg::MS_W-1:0];
            tgr_pkg::REG_HOLD_RADIUS:
                cfg_now.hold_radius     = value[tgr_pkg::THR_W-1:0];
            tgr_pkg::REG_CLICK_WINDOW_MS:
                cfg_now.click_window_ms = value[tgr_pkg::MS_W-1:0];
            tgr_pkg::REG_PANEL_W:
                cfg_now.panel_w         = value[tgr_pkg::SIZE_W-1:0];
            tgr_pkg::REG_PANEL_H:
                cfg_now.panel_h         = value[tgr_pkg::SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int thr, input int lp_ms, input int lp_dist,
                              input int tap_ms, input int width, input int height);
        write_reg(tgr_pkg::REG_MOVE_LIMIT, thr);
        write_reg(tgr_pkg::REG_LONG_PRESS_MS, lp_ms);
        write_reg(tgr_pkg::REG_HOLD_RADIUS, lp_dist);
        write_reg(tgr_pkg::REG_CLICK_WINDOW_MS, tap_ms);
        write_reg(tgr_pkg::REG_PANEL_W, width);
        write_reg(tgr_pkg::REG_PANEL_H, height);
        n_settings++;
        @(negedge clk);
    endtask

    task automatic add_sample(input int unsigned cnt, input int x, input int y,
                              input logic [tgr_pkg::TIME_W-1:0] stamp);
        tgr_pkg::sample_t s;
        s.touch_count = tgr_pkg::CNT_W'(cnt);
        s.raw_x       = tgr_pkg::COORD_BITS'(x);
        s.raw_y       = tgr_pkg::COORD_BITS'(y);
        s.now_ms      = stamp;
        sample_pending.push_back(s);
        samples_queued++;
    endtask

    function automatic int nudge(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    // Queue one touch session: mostly taps, drags and long presses shaped
    // around the current settings, the rest free-running noise.
    task automatic add_session();
        int style;
        int steps;
        int spread;
        int pace;
        int x0;
        int y0;
        int xmax;
        int ymax;
        style = $urandom_range(0, 9);
        xmax  = (cfg_now.panel_w == '0) ? 0 : cfg_now.panel_w - 1;
        ymax  = (cfg_now.panel_h == '0) ? 0 : cfg_now.panel_h - 1;
        x0    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, xmax);
        y0    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, ymax);
        case (style)
            0, 1, 2:
            begin   // tap: small wiggle, quick lift
                spread = $urandom_range(0, cfg_now.move_limit);
                steps  = $urandom_range(0, 2);
                pace   = cfg_now.click_window_ms / 3 + 1;
            end
            3, 4, 5:
            begin   // drag: move past the threshold
                spread = cfg_now.move_limit + $urandom_range(1, 100);
                steps  = $urandom_range(1, 5);
                pace   = $urandom_range(5, 60);
            end
            6, 7:
            begin   // long press: hold still past the press time
                spread = (cfg_now.hold_radius == '0) ? 0 :
                         $urandom_range(0, cfg_now.hold_radius - 1) / 2;
                steps  = $urandom_range(1, 4);
                pace   = cfg_now.long_press_ms / steps + $urandom_range(2, 80);
            end
            default:
            begin   // noise: any count, anywhere, any time step
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 3) == 0)
                        ms_now += $urandom();
                    else
                        ms_now += $urandom_range(0, 700);
                    add_sample($urandom_range(0, 15), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), ms_now);
                end
                return;
            end
        endcase
        add_sample($urandom_range(1, 15), x0, y0, ms_now);
        repeat (steps)
        begin
            ms_now += $urandom_range(pace / 2 + 1, pace);
            add_sample($urandom_range(1, 15), nudge(x0, spread), nudge(y0, spread), ms_now);
        end
        ms_now += $urandom_range(1, pace);
        add_sample(0, $urandom_range(0, 4095), $urandom_range(0, 4095), ms_now);
    endtask

    // Hold off the sender until every owed word has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_pending.size() != 0 || sample_valid || gesture_exp.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(input int n_items, input bit calm, input bit choke);
        int goal;
        goal   = samples_queued + n_items;
        tx_max = calm ? 0 : 3;
        rx_max = calm ? 0 : 3;
        ms_now = $urandom();
        // Stall the receiver while the sender keeps pushing so the queue fills.
        if (choke)
            choke_seq++;
        while (samples_queued < goal)
            add_session();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg_now.move_limit      = tgr_pkg::MOVE_LIMIT_RST;
        cfg_now.long_press_ms   = tgr_pkg::LONG_PRESS_MS_RST;
        cfg_now.hold_radius     = tgr_pkg::HOLD_RADIUS_RST;
        cfg_now.click_window_ms = tgr_pkg::CLICK_WINDOW_MS_RST;
        cfg_now.panel_w         = tgr_pkg::PANEL_W_RST;
        cfg_now.panel_h         = tgr_pkg::PANEL_H_RST;
        touching        = 1'b0;
        dragging        = 1'b0;
        long_press_done = 1'b0;
        anchor_x        = '0;
        anchor_y        = '0;
        anchor_ms       = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pass on reset settings (threshold 5, press 500 ms,
        // distance 20, tap 200 ms, 800x480 screen).
        add_sample(0, 4095, 4095, 32'd10);           // lift while untouched: silent
        add_sample(15, 4095, 4095, 32'd1000);        // clamp to bottom-right corner
        add_sample(0, 0, 0, 32'd1100);               // quick lift: left click
        add_sample(1, 0, 0, 32'd2000);
        add_sample(3, 10, 0, 32'd2010);              // move past threshold: drag starts
        add_sample(2, 300, 200, 32'd2600);           // dragging blocks long press
        add_sample(0, 0, 0, 32'd2700);               // drag ends: left release
        add_sample(4, 100, 100, 32'd3000);
        add_sample(5, 102, 101, 32'd3600);           // still hold: right click
        add_sample(6, 200, 200, 32'd3700);           // no drag once long press fired
        add_sample(0, 0, 0, 32'd3800);               // silent lift after long press
        add_sample(7, 50, 50, 32'd4000);
        add_sample(8, 60, 50, 32'd4700);             // drag and long press due: drag wins
        add_sample(0, 0, 0, 32'd4710);
        add_sample(9, 200, 200, 32'd5000);
        add_sample(0, 0, 0, 32'd5200);               // lift right at tap timeout: silent
        add_sample(10, 200, 200, 32'd6000);
        add_sample(11, 205, 195, 32'd6001);          // move equal to threshold: no drag
        add_sample(0, 0, 0, 32'd6199);               // lift just inside tap timeout
        add_sample(12, 4095, 0, 32'hFFFF_FFF0);
        add_sample(0, 0, 0, 32'h0000_0050);          // elapsed time across the wrap
        add_sample(13, 0, 4095, 32'h0000_1000);
        add_sample(14, 3000, 3000, 32'h0000_1300);   // drag to the far corner
        add_sample(0, 4095, 4095, 32'h0000_1400);
        wait_drained();

        // Extremes: everything drags, instant long press, huge tap window,
        // full-size screen. No idling, plus a long receiver hold-off.
        write_reg(REG_UNMAPPED, $urandom());
        set_config(0, 0, 4095, 65535, 4096, 4096);
        run_random(100, 1'b1, 1'b1);

        // Opposite extremes: no drag, no long press, no click, zero-width screen of height one.
        set_config(4095, 65535, 0, 0, 0, 1);
        run_random(60, 1'b0, 1'b0);

        // Random mid-range settings with another hold-off.
        set_config($urandom_range(0, 30), $urandom_range(50, 1500), $urandom_range(1, 60),
                   $urandom_range(50, 500), $urandom_range(1, 4096), $urandom_range(1, 4096));
        run_random(120, 1'b0, 1'b1);

        // Back to the usual panel settings.
        set_config(5, 500, 20, 200, 800, 480);
        run_random(120, 1'b0, 1'b0);

        if (gesture_exp.size() != 0)
        begin
            $error("%0d gesture words never arrived", gesture_exp.size());
            n_errors++;
        end

        $display("Run covered %0d touch samples and %0d gesture words over %0d settings",
                 samples_sent, words_checked, n_settings);
        $display("  left presses seen: %0d, right clicks seen: %0d, mismatches: %0d",
                 n_left_press, n_right_press, n_errors);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== touch_gesture_recognizer.f =====
rtl/core/tgr_pkg.sv
rtl/core/tgr_front.sv
rtl/core/tgr_queue.sv
rtl/core/tgr_back.sv
rtl/core/touch_gesture_recognizer.sv
rtl/core/tgr_checker.sv
verif/tb_top.sv
